// ===== hw/rtl/triangle_barycentric_coords_assert.svh =====
// Assertion macros used by the checker file of the barycentric block.
`ifndef TRIANGLE_BARYCENTRIC_COORDS_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_COORDS_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define BARY_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define BARY_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/bary_pkg.sv =====
// Package of widths and types for the barycentric weight pipeline.
package bary_pkg;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 24;
    localparam int OUT_W      = 32;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DEN_W      = PROD_W + 1;
    localparam int NUM_W      = DEN_W + 2;
    localparam int INT_BITS   = OUT_W - 1 - FRAC_BITS;
    localparam int QB         = INT_BITS + 1 + FRAC_BITS + 1;
    localparam int DD_W       = DEN_W + INT_BITS;
    localparam int R_W        = DD_W + 1;
    localparam int STEPS      = 3;
    localparam int NSTG       = (QB + STEPS - 1) / STEPS;

    typedef struct packed {
        logic               neg;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } div_in_t;
endpackage

// ===== hw/rtl/bary_front.sv =====
// Edge vectors, cross products and operand magnitudes in four pipeline stages.
module bary_front
    import bary_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid_in,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    output logic                         valid_out,
    output logic                         zero_out,
    output div_in_t                      op_u,
    output div_in_t                      op_v,
    output div_in_t                      op_w
);
    logic [3:0] valid_reg;
    logic signed [DIFF_W-1:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [DEN_W-1:0]  den_reg, nv_reg, nw_reg;
    logic signed [DEN_W-1:0]  den_next, nv_next, nw_next;
    logic signed [NUM_W-1:0]  nu_next, nv_ext, nw_ext;
    div_in_t op_u_reg, op_v_reg, op_w_reg, op_u_next, op_v_next, op_w_next;
    logic zero_reg;

    function automatic div_in_t make_op(input logic signed [NUM_W-1:0] n,
                                        input logic signed [DEN_W-1:0] d);
        div_in_t o;
        o.neg = n[NUM_W-1] ^ d[DEN_W-1];
        o.num = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
        o.den = d[DEN_W-1] ? DEN_W'(-d) : DEN_W'(d);
        return o;
    endfunction

    always_comb
    begin
        den_next  = DEN_W'(p0_reg) - DEN_W'(p1_reg);
        nv_next   = DEN_W'(p2_reg) - DEN_W'(p3_reg);
        nw_next   = DEN_W'(p4_reg) - DEN_W'(p5_reg);
        nv_ext    = NUM_W'(nv_reg);
        nw_ext    = NUM_W'(nw_reg);
        nu_next   = NUM_W'(den_reg) - nv_ext - nw_ext;
        op_u_next = make_op(nu_next, den_reg);
        op_v_next = make_op(nv_ext, den_reg);
        op_w_next = make_op(nw_ext, den_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e0x_reg  <= DIFF_W'(bx) - DIFF_W'(ax);
            e0y_reg  <= DIFF_W'(by) - DIFF_W'(ay);
            e1x_reg  <= DIFF_W'(cx) - DIFF_W'(ax);
            e1y_reg  <= DIFF_W'(cy) - DIFF_W'(ay);
            e2x_reg  <= DIFF_W'(px) - DIFF_W'(ax);
            e2y_reg  <= DIFF_W'(py) - DIFF_W'(ay);
            p0_reg   <= e0x_reg * e1y_reg;
            p1_reg   <= e0y_reg * e1x_reg;
            p2_reg   <= e2x_reg * e1y_reg;
            p3_reg   <= e2y_reg * e1x_reg;
            p4_reg   <= e0x_reg * e2y_reg;
            p5_reg   <= e0y_reg * e2x_reg;
            den_reg  <= den_next;
            nv_reg   <= nv_next;
            nw_reg   <= nw_next;
            op_u_reg <= op_u_next;
            op_v_reg <= op_v_next;
            op_w_reg <= op_w_next;
            zero_reg <= (den_reg == '0);
        end
    end

    assign valid_out = valid_reg[3];
    assign zero_out  = zero_reg;
    assign op_u      = op_u_reg;
    assign op_v      = op_v_reg;
    assign op_w      = op_w_reg;
endmodule

// ===== hw/rtl/bary_div.sv =====
// Pipelined restoring divider with rounding and saturation to a Q8.24 weight.
module bary_div
    import bary_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid_in,
    input  logic                    zero_in,
    input  div_in_t                 op,
    output logic                    valid_out,
    output logic                    zero_out,
    output logic signed [OUT_W-1:0] weight
);
    logic [NSTG+1:0]   valid_reg;
    logic [NSTG:0]     zero_reg;
    logic [NSTG:0]     neg_reg;
    logic [NSTG:0]     big_reg;
    logic [R_W-1:0]    r_reg  [0:NSTG];
    logic [DD_W-1:0]   dd_reg [0:NSTG];
    logic [QB-1:0]     q_reg  [0:NSTG];
    logic [R_W-1:0]    r_next [0:NSTG-1];
    logic [QB-1:0]     q_next [0:NSTG-1];
    logic [QB:0]       m_sum;
    logic [QB-1:0]     m;
    logic signed [OUT_W-1:0] weight_next;
    logic signed [OUT_W-1:0] weight_reg;
    logic              zero_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NSTG:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= zero_in;
            neg_reg[0]  <= op.neg;
            big_reg[0]  <= ({(INT_BITS + 1)'(0), op.num} >= {(NUM_W - DEN_W)'(0), op.den,
                            (INT_BITS + 1)'(0)});
            r_reg[0]    <= R_W'(op.num);
            dd_reg[0]   <= {op.den, INT_BITS'(0)};
            q_reg[0]    <= '0;
        end
    end

    for (genvar s = 0; s < NSTG; s++)
    begin : g_stage
        always_comb
        begin
            logic [R_W-1:0] r;
            logic [QB-1:0]  q;
            logic           bit_q;
            r = r_reg[s];
            q = q_reg[s];
            for (int j = 0; j < STEPS; j++)
            begin
                if (s * STEPS + j < QB)
                begin
                    bit_q = (r >= R_W'(dd_reg[s]));
                    if (bit_q)
                    begin
                        r = r - R_W'(dd_reg[s]);
                    end
                    r = {r[R_W-2:0], 1'b0};
                    q = {q[QB-2:0], bit_q};
                end
            end
            r_next[s] = r;
            q_next[s] = q;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s+1]    <= r_next[s];
                q_reg[s+1]    <= q_next[s];
                dd_reg[s+1]   <= dd_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                big_reg[s+1]  <= big_reg[s];
                zero_reg[s+1] <= zero_reg[s];
            end
        end
    end

    always_comb
    begin
        m_sum = {1'b0, q_reg[NSTG]} + (QB + 1)'(1);
        m     = m_sum[QB:1];
        if (zero_reg[NSTG])
        begin
            weight_next = '0;
        end
        else if (!neg_reg[NSTG])
        begin
            if (big_reg[NSTG] || (m > QB'({1'b0, {(OUT_W - 1){1'b1}}})))
            begin
                weight_next = {1'b0, {(OUT_W - 1){1'b1}}};
            end
            else
            begin
                weight_next = OUT_W'(m);
            end
        end
        else
        begin
            if (big_reg[NSTG] || (m > QB'({1'b1, {(OUT_W - 1){1'b0}}})))
            begin
                weight_next = {1'b1, {(OUT_W - 1){1'b0}}};
            end
            else
            begin
                weight_next = OUT_W'(-m);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            weight_reg   <= weight_next;
            zero_out_reg <= zero_reg[NSTG];
        end
    end

    assign valid_out = valid_reg[NSTG+1];
    assign zero_out  = zero_out_reg;
    assign weight    = weight_reg;
endmodule

// ===== hw/rtl/triangle_barycentric_coords.sv =====
// Top level of the barycentric weight pipeline for a 2-D triangle.
// Input channel: in_valid and in_stall carry one beat holding the query point and the three
// vertices as signed 16-bit coordinates. Output channel: out_valid and out_stall carry one
// beat with weight_u, weight_v and weight_w in signed Q8.24, saturated, and degenerate.
// Each input beat yields exactly one output beat, in order.
// Four stages form the edges, cross products and magnitudes, one stage prepares the
// dividers, eleven stages each resolve three quotient bits, and the output register takes
// the rounded and saturated weights.
// One beat per cycle unless stalled; three dividers run side by side for u, v and w.
// A zero cross product gives zero weights with degenerate set.
// Reset empties the pipeline; no output beat appears until beats have been taken.
// When out_stall holds while a beat waits at the output, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing inside is lost or repeated.
module triangle_barycentric_coords
    import bary_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] vert_a_x,
    input  logic signed [COORD_BITS-1:0] vert_a_y,
    input  logic signed [COORD_BITS-1:0] vert_b_x,
    input  logic signed [COORD_BITS-1:0] vert_b_y,
    input  logic signed [COORD_BITS-1:0] vert_c_x,
    input  logic signed [COORD_BITS-1:0] vert_c_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [OUT_W-1:0]      weight_u,
    output logic signed [OUT_W-1:0]      weight_v,
    output logic signed [OUT_W-1:0]      weight_w,
    output logic                         degenerate
);
    logic    en;
    logic    f_valid;
    logic    f_zero;
    div_in_t op_u, op_v, op_w;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    bary_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (in_valid),
        .px        (point_x),
        .py        (point_y),
        .ax        (vert_a_x),
        .ay        (vert_a_y),
        .bx        (vert_b_x),
        .by        (vert_b_y),
        .cx        (vert_c_x),
        .cy        (vert_c_y),
        .valid_out (f_valid),
        .zero_out  (f_zero),
        .op_u      (op_u),
        .op_v      (op_v),
        .op_w      (op_w)
    );

    bary_div u_div_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (f_valid),
        .zero_in   (f_zero),
        .op        (op_u),
        .valid_out (out_valid),
        .zero_out  (degenerate),
        .weight    (weight_u)
    );

    bary_div u_div_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (f_valid),
        .zero_in   (f_zero),
        .op        (op_v),
        .valid_out (),
        .zero_out  (),
        .weight    (weight_v)
    );

    bary_div u_div_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (f_valid),
        .zero_in   (f_zero),
        .op        (op_w),
        .valid_out (),
        .zero_out  (),
        .weight    (weight_w)
    );
endmodule

// ===== hw/rtl/bary_checker.sv =====
// Port-level checker for the barycentric block and its bind to the top level.
`include "triangle_barycentric_coords_assert.svh"

module bary_checker
    import bary_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic signed [COORD_BITS-1:0] point_x,
    input logic signed [COORD_BITS-1:0] point_y,
    input logic signed [COORD_BITS-1:0] vert_a_x,
    input logic signed [COORD_BITS-1:0] vert_a_y,
    input logic signed [COORD_BITS-1:0] vert_b_x,
    input logic signed [COORD_BITS-1:0] vert_b_y,
    input logic signed [COORD_BITS-1:0] vert_c_x,
    input logic signed [COORD_BITS-1:0] vert_c_y,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [OUT_W-1:0]      weight_u,
    input logic signed [OUT_W-1:0]      weight_v,
    input logic signed [OUT_W-1:0]      weight_w,
    input logic                         degenerate
);
    `BARY_ASSERT_SAME(a_stall_needs_result, in_stall, out_valid)
    `BARY_ASSERT_SAME(a_no_stall_when_free, !out_stall, !in_stall)
    `BARY_ASSERT_SAME(a_degenerate_zero, out_valid && degenerate,
        weight_u == '0 && weight_v == '0 && weight_w == '0)
    `BARY_ASSERT_NEXT(a_held_beat, out_valid && out_stall,
        out_valid && $stable(weight_u) && $stable(weight_v) && $stable(weight_w))
endmodule

bind triangle_barycentric_coords bary_checker u_bary_checker (.*);

// ===== test/tb_triangle_barycentric_coords.sv =====
// Self-checking testbench for the barycentric weight pipeline of a 2-D triangle.
`timescale 1ns / 100ps

module tb_triangle_barycentric_coords;
    import bary_pkg::*;

    typedef struct {
        logic signed [COORD_BITS-1:0] px, py, ax, ay, bx, by, cx, cy;
    } query_t;

    typedef struct {
        logic signed [OUT_W-1:0] u, v, w;
        logic                    degen;
    } weights_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [COORD_BITS-1:0] point_x = '0, point_y = '0;
    logic signed [COORD_BITS-1:0] vert_a_x = '0, vert_a_y = '0;
    logic signed [COORD_BITS-1:0] vert_b_x = '0, vert_b_y = '0;
    logic signed [COORD_BITS-1:0] vert_c_x = '0, vert_c_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [OUT_W-1:0] weight_u, weight_v, weight_w;
    logic degenerate;

    query_t   pending_queries[$];
    weights_t expected_weights[$];
    int       mismatches = 0;
    int       beats_checked = 0;
    int       degenerate_seen = 0;
    int       cycle_count = 0;
    bit       calm = 1'b0;
    bit       hold_off = 1'b0;
    bit       in_taken = 1'b0;

    triangle_barycentric_coords dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Rounded, saturated Q8.24 value of num/den, ties away from zero.
    function automatic logic signed [OUT_W-1:0] scaled_ratio(longint num, longint den);
        bit       neg;
        longint   n, d, q, r, m;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = n / d;
        r = n % d;
        if (q > (64'sd1 << (31 - FRAC_BITS)))
            return neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        m = q;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            r = r << 1;
            m = m << 1;
            if (r >= d)
            begin
                r = r - d;
                m = m | 1;
            end
        end
        r = r << 1;
        if (r >= d)
            m = m + 1;
        if (neg)
            m = -m;
        if (m > 64'sh7FFFFFFF)
            m = 64'sh7FFFFFFF;
        if (m < -64'sh80000000)
            m = -64'sh80000000;
        return m[OUT_W-1:0];
    endfunction

    function automatic weights_t predict_weights(query_t q);
        weights_t wt;
        longint   e0x, e0y, e1x, e1y, e2x, e2y, den, nv, nw;
        e0x = longint'(q.bx) - q.ax;
        e0y = longint'(q.by) - q.ay;
        e1x = longint'(q.cx) - q.ax;
        e1y = longint'(q.cy) - q.ay;
        e2x = longint'(q.px) - q.ax;
        e2y = longint'(q.py) - q.ay;
        den = e0x * e1y - e0y * e1x;
        nv  = e2x * e1y - e2y * e1x;
        nw  = e0x * e2y - e0y * e2x;
        if (den == 0)
        begin
            wt.u = '0;
            wt.v = '0;
            wt.w = '0;
            wt.degen = 1'b1;
        end
        else
        begin
            wt.u = scaled_ratio(den - nv - nw, den);
            wt.v = scaled_ratio(nv, den);
            wt.w = scaled_ratio(nw, den);
            wt.degen = 1'b0;
        end
        return wt;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord(int spread);
        case ($urandom_range(0, 3))
            0: return COORD_BITS'($urandom);
            1: return $urandom_range(0, 1) ? COORD_BITS'(32'h7FFF - $urandom_range(0, 3))
                                            : COORD_BITS'(32'h8000 + $urandom_range(0, 3));
            default: return COORD_BITS'($signed($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    task automatic add_query(int px, int py, int ax, int ay, int bx, int by, int cx, int cy);
        query_t q;
        q.px = COORD_BITS'(px); q.py = COORD_BITS'(py);
        q.ax = COORD_BITS'(ax); q.ay = COORD_BITS'(ay);
        q.bx = COORD_BITS'(bx); q.by = COORD_BITS'(by);
        q.cx = COORD_BITS'(cx); q.cy = COORD_BITS'(cy);
        pending_queries.push_back(q);
    endtask

    task automatic add_random_query();
        query_t q;
        int     spread;
        spread = $urandom_range(0, 1) ? 16 : 32767;
        q.px = rand_coord(spread); q.py = rand_coord(spread);
        q.ax = rand_coord(spread); q.ay = rand_coord(spread);
        q.bx = rand_coord(spread); q.by = rand_coord(spread);
        q.cx = rand_coord(spread); q.cy = rand_coord(spread);
        case ($urandom_range(0, 9))
            0:
            begin
                q.bx = q.ax;
                q.by = q.ay;
            end
            1:
            begin
                q.cx = COORD_BITS'(q.ax + 2 * (q.bx - q.ax));
                q.cy = COORD_BITS'(q.ay + 2 * (q.by - q.ay));
            end
            2:
            begin
                q.px = q.bx;
                q.py = q.by;
            end
            default: ;
        endcase
        pending_queries.push_back(q);
    endtask

    task automatic report_mismatch(string what, logic signed [OUT_W-1:0] got,
                                   logic signed [OUT_W-1:0] want);
        $display("mismatch on beat %0d: %s got %0d expected %0d",
                 beats_checked, what, got, want);
        mismatches++;
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_queries.size() > 0 && !hold_off
                    && (calm || $urandom_range(0, 99) >= 19))
                begin
                    query_t q;
                    q = pending_queries.pop_front();
                    in_valid <= 1'b1;
                    point_x <= q.px; point_y <= q.py;
                    vert_a_x <= q.ax; vert_a_y <= q.ay;
                    vert_b_x <= q.bx; vert_b_y <= q.by;
                    vert_c_x <= q.cx; vert_c_y <= q.cy;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 19);
        end
    end

    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            expected_weights.push_back(predict_weights('{point_x, point_y, vert_a_x, vert_a_y,
                                                         vert_b_x, vert_b_y, vert_c_x, vert_c_y}));
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_weights.size() == 0)
            begin
                report_mismatch("unexpected output beat", weight_u, '0);
            end
            else
            begin
                weights_t want;
                want = expected_weights.pop_front();
                if (weight_u !== want.u)
                    report_mismatch("weight_u", weight_u, want.u);
                if (weight_v !== want.v)
                    report_mismatch("weight_v", weight_v, want.v);
                if (weight_w !== want.w)
                    report_mismatch("weight_w", weight_w, want.w);
                if (degenerate !== want.degen)
                    report_mismatch("degenerate", OUT_W'(degenerate), OUT_W'(want.degen));
                if (want.degen)
                    degenerate_seen++;
            end
            beats_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 200000)
        begin
            $display("timeout with %0d beats still expected", expected_weights.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        add_query(0, 0, 0, 0, 10, 0, 0, 10);
        add_query(10, 0, 0, 0, 10, 0, 0, 10);
        add_query(0, 10, 0, 0, 10, 0, 0, 10);
        add_query(3, 3, 0, 0, 10, 0, 0, 10);
        add_query(5, 5, 0, 0, 10, 0, 0, 10);
        add_query(1, 1, 0, 0, 3, 0, 0, 3);
        add_query(2, 1, 0, 0, 3, 0, 0, 3);
        add_query(-32768, -32768, 0, 0, 1, 0, 0, 1);
        add_query(32767, 32767, 0, 0, 1, 0, 0, 1);
        add_query(32767, -32768, -32768, -32768, -32767, -32768, -32768, -32767);
        add_query(-32768, 32767, 32767, 32767, 32766, 32767, 32767, 32766);
        add_query(0, 0, -32768, -32768, 32767, -32768, -32768, 32767);
        add_query(0, 0, 32767, 32767, -32768, 32767, 32767, -32768);
        add_query(1, 2, 0, 0, 0, 0, 0, 0);
        add_query(1, 2, 5, 5, 5, 5, 9, 9);
        add_query(0, 0, 0, 0, 1, 1, 2, 2);
        add_query(-32768, -32768, -32768, -32768, 32767, 32767, 0, 0);
        add_query(1, 0, 0, 0, 3, 0, 0, 2);
        add_query(-1, 0, 0, 0, 3, 0, 0, 2);
        add_query(0, 0, 0, 0, 1, 1, -1, 1);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 600; i++)
            add_random_query();
        wait (pending_queries.size() == 0);
        @(negedge clk);
        hold_off = 1'b1;
        wait (expected_weights.size() == 0 && !in_valid);
        @(negedge clk);
        hold_off = 1'b0;
        calm = 1'b1;
        for (int i = 0; i < 300; i++)
            add_random_query();
        wait (pending_queries.size() == 0);
        @(negedge clk);
        calm = 1'b0;
        for (int i = 0; i < 300; i++)
            add_random_query();
        wait (pending_queries.size() == 0);
        @(posedge clk);
        wait (!in_valid);
        wait (expected_weights.size() == 0);
        repeat (40) @(posedge clk);
        $display("checked %0d output beats, %0d of them degenerate triangles",
                 beats_checked, degenerate_seen);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
